// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPL(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, ant, cons, msg)
`define ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

// ===== rtl/core/isort_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isort_pkg
// Types and constants shared by the insertion sorter cells and top level.
// ---------------------------------------------------------------------------
package isort_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     final_item;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] ins_value;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/isort_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isort_cell
// One place of the sorted list: compares against the broadcast value,
// takes its left neighbor or the new value on insert, its right on shift.
// ---------------------------------------------------------------------------
module isort_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  isort_pkg::t_cell_ctl                i_ctl,
    input  logic signed [isort_pkg::DATA_W-1:0] i_left_val,
    input  logic                                i_left_valid,
    input  logic                                i_left_gt,
    input  logic signed [isort_pkg::DATA_W-1:0] i_right_val,
    input  logic                                i_right_valid,
    output logic signed [isort_pkg::DATA_W-1:0] o_val,
    output logic                                o_valid,
    output logic                                o_gt
);

    logic signed [isort_pkg::DATA_W-1:0] r_val;
    logic signed [isort_pkg::DATA_W-1:0] n_val;
    logic                                r_valid;
    logic                                n_valid;
    logic                                w_gt;
    logic                                w_take;

    assign w_gt   = r_valid && (r_val > i_ctl.ins_value);
    // strictly greater entries move up; the first free place also takes one
    assign w_take = i_ctl.insert && (w_gt || (!r_valid && i_left_valid));

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_val   = i_right_val;
            n_valid = i_right_valid;
        end else if (w_take) begin
            n_val   = i_left_gt ? i_left_val : i_ctl.ins_value;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

// ===== rtl/core/insertion_sorter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// insertion_sorter_top
// Streaming insertion sort over a systolic row of compare-and-shift cells.
// ---------------------------------------------------------------------------
//  channel   ports                      transfer
//  input     start, busy, i_data        start high and busy low at the edge
//  result    o_strobe, o_data           every cycle o_strobe is high
//
//  An item is inserted in the cycle it is taken, or dropped if the list is full;
//  after a non-final one the next may follow at once. After a final one the
//  list leaves cell 0 one entry a cycle, with busy high until the last is out.
//  Reset clears the valid bits of the cells, the count and the drop flag.
//  The receiver cannot stall; results are never held back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module insertion_sorter_top #(
    parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  isort_pkg::t_in  i_data,
    output logic            o_strobe,
    output isort_pkg::t_out o_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    isort_pkg::t_state r_state;
    isort_pkg::t_state n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_dropped;
    logic              n_dropped;
    logic              w_accept;
    logic              w_full;
    logic              w_emit;
    isort_pkg::t_cell_ctl w_ctl;

    logic signed [isort_pkg::DATA_W-1:0] w_val   [DEPTH];
    logic                                w_valid [DEPTH];
    logic                                w_gt    [DEPTH];

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isort_pkg::ST_IDLE: begin
                if (w_accept && i_data.final_item) begin
                    n_state = isort_pkg::ST_EMIT;
                end
            end
            isort_pkg::ST_EMIT: begin
                if (r_count == CNT_ONE) begin
                    n_state = isort_pkg::ST_IDLE;
                end
            end
            default: n_state = isort_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy   = 1'b0;
        w_emit = 1'b0;
        unique case (r_state)
            isort_pkg::ST_IDLE: begin
                busy   = 1'b0;
                w_emit = 1'b0;
            end
            isort_pkg::ST_EMIT: begin
                busy   = 1'b1;
                w_emit = 1'b1;
            end
            default: begin
                busy   = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    assign w_ctl.insert    = w_accept && !w_full;
    assign w_ctl.shift     = w_emit;
    assign w_ctl.ins_value = i_data.value;

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_emit) begin
            // count down the entries still to send; clear the flag at the end
            n_count = r_count - CNT_ONE;
            if (r_count == CNT_ONE) begin
                n_dropped = 1'b0;
            end
        end else if (w_accept) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + CNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isort_pkg::ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [isort_pkg::DATA_W-1:0] w_lval;
        logic                                w_lvalid;
        logic                                w_lgt;
        logic signed [isort_pkg::DATA_W-1:0] w_rval;
        logic                                w_rvalid;

        if (gi == 0) begin : g_head
            assign w_lval   = '0;
            assign w_lvalid = 1'b1;
            assign w_lgt    = 1'b0;
        end else begin : g_body
            assign w_lval   = w_val[gi-1];
            assign w_lvalid = w_valid[gi-1];
            assign w_lgt    = w_gt[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rval   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_inner
            assign w_rval   = w_val[gi+1];
            assign w_rvalid = w_valid[gi+1];
        end

        isort_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_left_val    (w_lval),
            .i_left_valid  (w_lvalid),
            .i_left_gt     (w_lgt),
            .i_right_val   (w_rval),
            .i_right_valid (w_rvalid),
            .o_val         (w_val[gi]),
            .o_valid       (w_valid[gi]),
            .o_gt          (w_gt[gi])
        );
    end

    assign o_strobe            = w_emit;
    assign o_data.sorted_value = w_val[0];
    assign o_data.last_out     = (r_count == CNT_ONE);
    assign o_data.overflow     = r_dropped;

    `ASSERT_IMPL(a_emit_nonempty, busy, (r_count != '0) && w_valid[0], "emit with empty list")
    `ASSERT_NEXT(a_last_ends, o_strobe && o_data.last_out, !busy, "emission overran last entry")
    `ASSERT_IMPL(a_count_range, 1'b1, r_count <= CNT_FULL, "entry count beyond depth")
    `ASSERT_NEXT(a_nonfinal_quiet, w_accept && !i_data.final_item, !o_strobe,
                 "result after non-final item")

endmodule

// ===== tb/insertion_sorter_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// insertion_sorter_top_tb
// Drives lists of signed values into the sorter, one transfer per value with
// a flag on the last one. A scoreboard keeps its own sorted copy of each list
// and checks every emitted entry against it. The run covers single-entry
// lists, ties, extremes, full and overflowing lists, and random lists.
// ---------------------------------------------------------------------------
module insertion_sorter_top_tb;

    localparam int LIST_DEPTH  = isort_pkg::DEPTH_DEF;
    localparam int ITEM_TARGET = 370;
    localparam logic signed [isort_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [isort_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [isort_pkg::DATA_W-1:0] value;
        logic                                final_item;
        bit                                  pinned;
        isort_pkg::t_out                     result;
    } t_directed_row;

    localparam int N_DIRECTED = 19;

    // single-entry lists carry their result; the rest go through the scoreboard
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{VAL_MAX,   1'b1, 1'b1, '{VAL_MAX,   1'b1, 1'b0}},
        '{VAL_MIN,   1'b1, 1'b1, '{VAL_MIN,   1'b1, 1'b0}},
        '{32'sd0,    1'b1, 1'b1, '{32'sd0,    1'b1, 1'b0}},
        '{-32'sd1,   1'b1, 1'b1, '{-32'sd1,   1'b1, 1'b0}},
        '{32'sd7,    1'b0, 1'b0, '0},
        '{-32'sd3,   1'b0, 1'b0, '0},
        '{32'sd7,    1'b0, 1'b0, '0},
        '{VAL_MIN,   1'b0, 1'b0, '0},
        '{VAL_MAX,   1'b0, 1'b0, '0},
        '{32'sd0,    1'b0, 1'b0, '0},
        '{-32'sd3,   1'b0, 1'b0, '0},
        '{32'sd1,    1'b1, 1'b0, '0},
        '{32'sd3,    1'b0, 1'b0, '0},
        '{32'sd2,    1'b0, 1'b0, '0},
        '{32'sd1,    1'b0, 1'b0, '0},
        '{32'sd0,    1'b0, 1'b0, '0},
        '{-32'sd1,   1'b1, 1'b0, '0},
        '{-32'sd2,   1'b0, 1'b0, '0},
        '{32'sd2,    1'b1, 1'b0, '0}
    };

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    isort_pkg::t_in  i_data  = '0;
    logic            busy;
    logic            o_strobe;
    isort_pkg::t_out o_data;

    logic signed [isort_pkg::DATA_W-1:0] held_list [$];
    logic                                list_dropped = 1'b0;
    isort_pkg::t_out                     sorted_expect [$];
    bit                                  pinned_valid = 1'b0;
    isort_pkg::t_out                     pinned_result = '0;
    int                                  mismatch_count = 0;
    int                                  items_sent = 0;

    insertion_sorter_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void insert_into_list(logic signed [isort_pkg::DATA_W-1:0] v);
        int pos;
        if (held_list.size() >= LIST_DEPTH) begin
            list_dropped = 1'b1;
            return;
        end
        pos = held_list.size();
        // strictly greater entries move up, so ties keep arrival order
        while (pos > 0 && held_list[pos-1] > v) pos--;
        held_list.insert(pos, v);
    endfunction

    function automatic void report_mismatch(string what, isort_pkg::t_out want,
                                            isort_pkg::t_out got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected value %0d last %0b ovf %0b, %s %0d last %0b ovf %0b",
                     $time, what, want.sorted_value, want.last_out, want.overflow,
                     "got value", got.sorted_value, got.last_out, got.overflow);
    endfunction

    always @(posedge i_clk) begin : result_monitor
        isort_pkg::t_out want;
        if (i_rst_n) begin
            if (start && !busy) begin
                insert_into_list(i_data.value);
                if (i_data.final_item) begin
                    if (pinned_valid) begin
                        sorted_expect.push_back(pinned_result);
                        pinned_valid = 1'b0;
                    end else begin
                        for (int k = 0; k < held_list.size(); k++)
                            sorted_expect.push_back('{sorted_value: held_list[k],
                                                      last_out: (k == held_list.size() - 1),
                                                      overflow: list_dropped});
                    end
                    held_list.delete();
                    list_dropped = 1'b0;
                end
            end
            if (o_strobe) begin
                if (sorted_expect.size() == 0) begin
                    report_mismatch("unexpected result", '0, o_data);
                end else begin
                    want = sorted_expect.pop_front();
                    if (o_data.sorted_value !== want.sorted_value ||
                        o_data.last_out !== want.last_out ||
                        o_data.overflow !== want.overflow)
                        report_mismatch("wrong result", want, o_data);
                end
            end
        end
    end

    function automatic logic signed [isort_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
            5:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_value(input logic signed [isort_pkg::DATA_W-1:0] v, input logic fin,
                              input bit pin = 1'b0, input isort_pkg::t_out pin_result = '0);
        @(negedge i_clk);
        if (pin) begin
            pinned_valid  = 1'b1;
            pinned_result = pin_result;
        end
        start  <= 1'b1;
        i_data <= '{value: v, final_item: fin};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic maybe_idle();
        // hold start high through this stretch
        if (items_sent >= 230 && items_sent < 310) return;
        // idle each cycle with the same odds
        while ($urandom_range(0, 99) < 19) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_list(input int len);
        for (int i = 0; i < len; i++) begin
            maybe_idle();
            send_value(random_value(), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sorted_expect.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int len;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            maybe_idle();
            send_value(directed_rows[r].value, directed_rows[r].final_item,
                       directed_rows[r].pinned, directed_rows[r].result);
        end
        wait_drained();

        // exactly full, final dropped when full, extra value dropped before final
        send_list(LIST_DEPTH);
        send_list(LIST_DEPTH + 1);
        send_list(LIST_DEPTH + 2);

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 6);
                1:       len = $urandom_range(9, 40);
                default: len = $urandom_range(1, 8);
            endcase
            // trim the last list to the item budget
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_list(len);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && sorted_expect.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
